@@ hw/rtl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the frustum sphere cull block.
// ----------------------------------------------------------------------------
package fsc_pkg;

    // field and register widths
    localparam int COORD_W        = 16;
    localparam int HALF_W         = COORD_W + 1;
    localparam int SQ_W           = 2 * COORD_W - 1;
    localparam int SUM_W          = 32;
    localparam int RAD_W          = SUM_W / 2;
    localparam int SQRT_STEPS     = SUM_W / 2;
    localparam int PLANE_W        = 64;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int NORM_FRAC      = 14;
    localparam int DIST_W         = 20;
    localparam int NUM_PLANE_REGS = 6;
    localparam int CFG_IDX_W      = 3;

    // box centre in Q12.4
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_ctr;

    // partial remainder and root of the square root recurrence
    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] root;
    } t_sq;

    // item travelling along the plane cells
    typedef struct packed {
        t_ctr             ctr;
        logic [RAD_W-1:0] radius;
        logic             visible;
    } t_cull;

endpackage

@@ hw/rtl/frustum_sphere_cull.sv @@
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// Bounding-sphere test of an axis-aligned box against the frustum planes.
// ----------------------------------------------------------------------------
// Takes one box per cycle while o_stall is low and returns one visible bit
// per box, in order, through three front stages (centre and half-extent,
// squares, sum), 16 square-root cells that each settle one radius bit, and
// PLANES plane cells of two stages each (products, then distance compare).
// Every stage has its own valid and takes a new item whenever it is empty or
// moving on, so bubbles collapse and the block keeps taking items while a
// finished result waits, until full. Planes must be written by the user
// through the config port only while the block is idle; the block does not
// enforce it. They reset to zero; writes beyond the last plane are dropped.
module frustum_sphere_cull #(
    parameter int PLANES = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_min_x,
    input  logic signed [15:0]            i_max_x,
    input  logic signed [15:0]            i_min_y,
    input  logic signed [15:0]            i_max_y,
    input  logic signed [15:0]            i_min_z,
    input  logic signed [15:0]            i_max_z,
    input  logic                          i_cfg_we,
    input  logic [fsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fsc_pkg::PLANE_W-1:0]   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_visible
);
    import fsc_pkg::*;

    logic [PLANE_W-1:0]       r_plane [PLANES];

    logic                     r_v1, r_v2, r_v3;
    logic                     rdy1, rdy2, rdy3;
    t_ctr                     r_ctr1, r_ctr2, r_ctr3;
    logic signed [HALF_W-1:0] r_hx, r_hy, r_hz;
    logic [SQ_W-1:0]          r_qx, r_qy, r_qz;
    logic [SUM_W-1:0]         r_sum;

    logic signed [HALF_W-1:0] sum_x, sum_y, sum_z;
    t_ctr                     n_ctr;
    logic signed [2*HALF_W-1:0] pqx, pqy, pqz;

    logic                     sq_v   [SQRT_STEPS+1];
    logic                     sq_rdy [SQRT_STEPS+1];
    t_sq                      sq_d   [SQRT_STEPS+1];
    t_ctr                     sq_c   [SQRT_STEPS+1];

    logic                     pl_v   [PLANES+1];
    logic                     pl_rdy [PLANES+1];
    t_cull                    pl_d   [PLANES+1];

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLANES; k++) begin
                r_plane[k] <= '0;
            end
        end else begin
            for (int k = 0; k < PLANES; k++) begin
                if (i_cfg_we && i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_plane[k] <= i_cfg_data;
                end
            end
        end
    end

    // ready chain of the front stages
    assign rdy3    = !r_v3 || sq_rdy[0];
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    // centre by floor halving
    always_comb begin
        sum_x = HALF_W'(i_min_x) + HALF_W'(i_max_x);
        sum_y = HALF_W'(i_min_y) + HALF_W'(i_max_y);
        sum_z = HALF_W'(i_min_z) + HALF_W'(i_max_z);
        n_ctr.x = sum_x[HALF_W-1:1];
        n_ctr.y = sum_y[HALF_W-1:1];
        n_ctr.z = sum_z[HALF_W-1:1];
    end

    // squared half-extents
    assign pqx = r_hx * r_hx;
    assign pqy = r_hy * r_hy;
    assign pqz = r_hz * r_hz;

    // front stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_ctr1 <= n_ctr;
            r_hx   <= HALF_W'(i_min_x) - HALF_W'(n_ctr.x);
            r_hy   <= HALF_W'(i_min_y) - HALF_W'(n_ctr.y);
            r_hz   <= HALF_W'(i_min_z) - HALF_W'(n_ctr.z);
        end
        if (rdy2 && r_v1) begin
            r_ctr2 <= r_ctr1;
            r_qx   <= pqx[SQ_W-1:0];
            r_qy   <= pqy[SQ_W-1:0];
            r_qz   <= pqz[SQ_W-1:0];
        end
        if (rdy3 && r_v2) begin
            r_ctr3 <= r_ctr2;
            r_sum  <= SUM_W'(r_qx) + SUM_W'(r_qy) + SUM_W'(r_qz);
        end
    end

    // square root chain
    assign sq_v[0]      = r_v3;
    assign sq_d[0].rem  = r_sum;
    assign sq_d[0].root = '0;
    assign sq_c[0]      = r_ctr3;

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        fsc_sqrt_cell #(
            .STEP (s)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[s]),
            .o_ready (sq_rdy[s]),
            .i_sq    (sq_d[s]),
            .i_ctr   (sq_c[s]),
            .o_valid (sq_v[s+1]),
            .i_ready (sq_rdy[s+1]),
            .o_sq    (sq_d[s+1]),
            .o_ctr   (sq_c[s+1])
        );
    end

    // plane chain
    assign sq_rdy[SQRT_STEPS] = pl_rdy[0];
    assign pl_v[0]            = sq_v[SQRT_STEPS];
    assign pl_d[0].ctr        = sq_c[SQRT_STEPS];
    assign pl_d[0].radius     = sq_d[SQRT_STEPS].root[RAD_W-1:0];
    assign pl_d[0].visible    = 1'b1;

    for (genvar p = 0; p < PLANES; p++) begin : g_plane
        fsc_plane_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (r_plane[p]),
            .i_valid (pl_v[p]),
            .o_ready (pl_rdy[p]),
            .i_cull  (pl_d[p]),
            .o_valid (pl_v[p+1]),
            .i_ready (pl_rdy[p+1]),
            .o_cull  (pl_d[p+1])
        );
    end

    // result item
    assign pl_rdy[PLANES] = !i_stall;
    assign o_valid        = pl_v[PLANES];
    assign o_visible      = pl_d[PLANES].visible;

endmodule

@@ hw/rtl/fsc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// fsc_sqrt_cell
// One step of the integer square root: settles one bit of the radius.
// ----------------------------------------------------------------------------
module fsc_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fsc_pkg::t_sq  i_sq,
    input  fsc_pkg::t_ctr i_ctr,
    output logic          o_valid,
    input  logic          i_ready,
    output fsc_pkg::t_sq  o_sq,
    output fsc_pkg::t_ctr o_ctr
);
    import fsc_pkg::*;

    localparam logic [SUM_W-1:0] BIT_VAL = SUM_W'(1) << (SUM_W - 2 - 2 * STEP);

    logic           r_valid;
    t_sq            r_sq;
    t_ctr           r_ctr;
    t_sq            n_sq;
    logic [SUM_W:0] trial;

    // compare remainder against root plus current bit
    always_comb begin
        trial = {1'b0, i_sq.root} + {1'b0, BIT_VAL};
        if ({1'b0, i_sq.rem} >= trial) begin
            n_sq.rem  = i_sq.rem - trial[SUM_W-1:0];
            n_sq.root = (i_sq.root >> 1) + BIT_VAL;
        end else begin
            n_sq.rem  = i_sq.rem;
            n_sq.root = i_sq.root >> 1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sq  <= n_sq;
            r_ctr <= i_ctr;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
    assign o_ctr   = r_ctr;

endmodule

@@ hw/rtl/fsc_plane_cell.sv @@
// ----------------------------------------------------------------------------
// fsc_plane_cell
// Tests the sphere against one plane: products, then distance and compare.
// ----------------------------------------------------------------------------
module fsc_plane_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fsc_pkg::PLANE_W-1:0] i_plane,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fsc_pkg::t_cull              i_cull,
    output logic                        o_valid,
    input  logic                        i_ready,
    output fsc_pkg::t_cull              o_cull
);
    import fsc_pkg::*;

    logic signed [COORD_W-1:0]          nx, ny, nz, dd;
    logic                               r_va, r_vb;
    logic signed [PROD_W-1:0]           r_px, r_py, r_pz;
    logic signed [COORD_W-1:0]          r_d;
    t_cull                              r_ca, r_cb;
    t_cull                              n_cb;
    logic                               rdy_a, rdy_b;
    logic signed [PROD_W-NORM_FRAC-1:0] sx, sy, sz;
    logic signed [DIST_W-1:0]           plane_dist, rad_s, slack;

    // unpack plane register
    assign nx = i_plane[63:48];
    assign ny = i_plane[47:32];
    assign nz = i_plane[31:16];
    assign dd = i_plane[15:0];

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (rdy_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_px <= nx * i_cull.ctr.x;
            r_py <= ny * i_cull.ctr.y;
            r_pz <= nz * i_cull.ctr.z;
            r_d  <= dd;
            r_ca <= i_cull;
        end
    end

    // signed distance and compare with minus radius
    always_comb begin
        sx    = r_px[PROD_W-1:NORM_FRAC];
        sy    = r_py[PROD_W-1:NORM_FRAC];
        sz    = r_pz[PROD_W-1:NORM_FRAC];
        plane_dist = DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz) + DIST_W'(r_d);
        rad_s = DIST_W'({1'b0, r_ca.radius});
        slack = plane_dist + rad_s;
        n_cb  = r_ca;
        n_cb.visible = r_ca.visible && (slack > 0);
    end

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            r_cb <= n_cb;
        end
    end

    assign o_valid = r_vb;
    assign o_cull  = r_cb;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frustum_sphere_cull: a directed table of boxes,
// then random boxes under many plane sets, each result checked in order
// against a pinned bit or a bit-exact sphere-versus-plane predictor.
// ----------------------------------------------------------------------------
module testbench;

    import fsc_pkg::*;

    localparam int          NUM_PLANES   = 6;
    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 11;
    localparam int          MAX_IDLE     = 13;
    localparam int          PHASES       = 13;
    localparam int          PHASE_ITEMS  = 100;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          LIMIT_CYCLES = 400000;
    localparam int          DIR_ROWS     = 12;
    localparam logic [15:0] POS_UNIT     = 16'h4000;
    localparam logic [15:0] NEG_UNIT     = 16'hC000;

    // register map of the config port, the last two are unmapped
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RIGHT, REG_LEFT, REG_BOTTOM, REG_TOP, REG_FAR, REG_NEAR,
        REG_SPARE6, REG_SPARE7
    } t_plane_reg;

    typedef enum int {
        PS_ZERO, PS_MAX, PS_MIN, PS_ONES, PS_CORNER, PS_BOX, PS_NOISE
    } t_plane_set;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        t_box box;
        logic pinned;
        logic want;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [COORD_W-1:0]   i_min_x;
    logic signed [COORD_W-1:0]   i_max_x;
    logic signed [COORD_W-1:0]   i_min_y;
    logic signed [COORD_W-1:0]   i_max_y;
    logic signed [COORD_W-1:0]   i_min_z;
    logic signed [COORD_W-1:0]   i_max_z;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [PLANE_W-1:0]          i_cfg_data;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_visible;

    // planes as the block should hold them
    logic [PLANE_W-1:0] plane_shadow [NUM_PLANE_REGS];
    logic               visible_q [$];
    logic               pin_on;
    logic               pin_val;
    int                 mismatch_count;
    int                 cycle_count;
    int                 rx_hold_len;
    bit                 tx_quiet;
    bit                 rx_quiet;

    // boxes read off at a glance under zero planes: culled only at radius 0
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
          1'b1, 1'b0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
          1'b1, 1'b0},
        '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
          1'b1, 1'b0},
        '{'{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF},
          1'b1, 1'b1},
        '{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000},
          1'b1, 1'b1},
        '{'{16'sh0005, 16'sh0006, -16'sh0007, -16'sh0006, 16'sh0000, 16'sh0001},
          1'b1, 1'b0},
        '{'{16'sh0004, 16'sh0006, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
          1'b1, 1'b1},
        '{'{-16'sh0003, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
          1'b1, 1'b1},
        '{'{16'sh0000, 16'sh0000, 16'sh0002, 16'sh0000, 16'sh0000, 16'sh0000},
          1'b1, 1'b1},
        '{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF},
          1'b1, 1'b1},
        '{'{16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF, -16'sh0001, -16'sh0001},
          1'b1, 1'b1},
        '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh0001},
          1'b1, 1'b0}
    };

    frustum_sphere_cull #(
        .PLANES     (NUM_PLANES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_min_x    (i_min_x),
        .i_max_x    (i_max_x),
        .i_min_y    (i_min_y),
        .i_max_y    (i_max_y),
        .i_min_z    (i_min_z),
        .i_max_z    (i_max_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_visible  (o_visible)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sphere test of one box against the shadow planes
    function automatic logic box_visible(input t_box b);
        longint lo [3];
        longint hi [3];
        longint ctr [3];
        longint nrm [3];
        longint half;
        longint sumsq;
        longint radius;
        longint trial;
        longint offset;
        longint plane_dist;
        logic   verdict;
        lo[0] = $signed(b.min_x);
        hi[0] = $signed(b.max_x);
        lo[1] = $signed(b.min_y);
        hi[1] = $signed(b.max_y);
        lo[2] = $signed(b.min_z);
        hi[2] = $signed(b.max_z);
        sumsq = 0;
        for (int a = 0; a < 3; a++) begin
            ctr[a] = (lo[a] + hi[a]) >>> 1;
            half   = lo[a] - ctr[a];
            sumsq  = sumsq + half * half;
        end
        // floor square root, one bit at a time from the top
        radius = 0;
        for (int k = RAD_W - 1; k >= 0; k--) begin
            trial = radius | (longint'(1) << k);
            if (trial * trial <= sumsq) radius = trial;
        end
        verdict = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            nrm[0] = $signed(plane_shadow[p][63:48]);
            nrm[1] = $signed(plane_shadow[p][47:32]);
            nrm[2] = $signed(plane_shadow[p][31:16]);
            offset = $signed(plane_shadow[p][15:0]);
            plane_dist = ((nrm[0] * ctr[0]) >>> NORM_FRAC)
                       + ((nrm[1] * ctr[1]) >>> NORM_FRAC)
                       + ((nrm[2] * ctr[2]) >>> NORM_FRAC) + offset;
            if (plane_dist <= -radius) verdict = 1'b0;
        end
        return verdict;
    endfunction

    function automatic logic [15:0] extreme_half();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // one plane word of the given set; the box set is a box around the origin
    function automatic logic [PLANE_W-1:0] plane_word(input t_plane_set set,
                                                      input t_plane_reg reg_id);
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [15:0] dd;
        case (set)
            PS_ZERO:   return '0;
            PS_MAX:    return {4{16'h7FFF}};
            PS_MIN:    return {4{16'h8000}};
            PS_ONES:   return '1;
            PS_CORNER: return {extreme_half(), extreme_half(),
                               extreme_half(), extreme_half()};
            PS_NOISE:  return {$urandom, $urandom};
            default: begin
                nx = 16'($urandom_range(0, 255)) - 16'd128;
                ny = 16'($urandom_range(0, 255)) - 16'd128;
                nz = 16'($urandom_range(0, 255)) - 16'd128;
                dd = 16'($urandom_range(0, 12000));
                case (reg_id)
                    REG_RIGHT:  nx = NEG_UNIT;
                    REG_LEFT:   nx = POS_UNIT;
                    REG_BOTTOM: ny = POS_UNIT;
                    REG_TOP:    ny = NEG_UNIT;
                    REG_FAR:    nz = NEG_UNIT;
                    default:    nz = POS_UNIT;
                endcase
                return {nx, ny, nz, dd};
            end
        endcase
    endfunction

    // mostly small well-formed boxes, some wide, flat or flipped ones
    function automatic t_box random_box();
        logic signed [15:0] lo [3];
        logic signed [15:0] hi [3];
        int                 pick;
        int                 c;
        int                 h;
        t_box               b;
        pick = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++) begin
            c = int'($urandom_range(0, 16383)) - 8192;
            h = $urandom_range(0, 511);
            if (pick < 15) begin
                lo[a] = 16'($urandom);
                hi[a] = 16'($urandom);
            end else if (pick < 75) begin
                lo[a] = 16'(c - h);
                hi[a] = 16'(c + h);
            end else if (pick < 85) begin
                lo[a] = 16'($urandom);
                hi[a] = lo[a] + 16'($urandom_range(0, 1));
            end else begin
                lo[a] = 16'(c + h);
                hi[a] = 16'(c - h);
            end
        end
        b.min_x = lo[0];
        b.max_x = hi[0];
        b.min_y = lo[1];
        b.max_y = hi[1];
        b.min_z = lo[2];
        b.max_z = hi[2];
        return b;
    endfunction

    // one box on the input channel, held until taken
    task automatic send_box(input t_box b, input logic pinned, input logic want);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_min_x <= b.min_x;
        i_max_x <= b.max_x;
        i_min_y <= b.min_y;
        i_max_y <= b.max_y;
        i_min_z <= b.min_z;
        i_max_z <= b.max_z;
        pin_on  <= pinned;
        pin_val <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    // all six planes plus junk to the unmapped indexes
    task automatic load_planes(input t_plane_set set);
        t_plane_reg reg_id;
        for (int i = 0; i < 2 ** CFG_IDX_W; i++) begin
            reg_id = t_plane_reg'(i);
            i_cfg_we  <= 1'b1;
            i_cfg_idx <= reg_id;
            if (i < NUM_PLANE_REGS) begin
                plane_shadow[i] = plane_word(set, reg_id);
                i_cfg_data     <= plane_shadow[i];
            end else begin
                i_cfg_data <= {$urandom, $urandom};
            end
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (visible_q.size() != 0);
    endtask

    // input side
    initial begin : tx_side
        t_plane_set set;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_min_x    <= '0;
        i_max_x    <= '0;
        i_min_y    <= '0;
        i_max_y    <= '0;
        i_min_z    <= '0;
        i_max_z    <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_RIGHT;
        i_cfg_data <= '0;
        pin_on     <= 1'b0;
        pin_val    <= 1'b0;
        mismatch_count = 0;
        rx_hold_len    = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        for (int p = 0; p < NUM_PLANE_REGS; p++) plane_shadow[p] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset planes, then again under max planes
        for (int r = 0; r < DIR_ROWS; r++)
            send_box(dir_rows[r].box, dir_rows[r].pinned, dir_rows[r].want);
        i_valid <= 1'b0;
        wait_drained();
        load_planes(PS_MAX);
        for (int r = 0; r < DIR_ROWS; r++)
            send_box(dir_rows[r].box, 1'b0, 1'b0);
        i_valid <= 1'b0;
        wait_drained();

        // random phases, each with its own plane set and idling mix
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set = PS_MIN;
                1: set = PS_ONES;
                2: set = PS_ZERO;
                3: set = PS_CORNER;
                4: set = PS_BOX;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       set = PS_NOISE;
                        1:       set = PS_CORNER;
                        default: set = PS_BOX;
                    endcase
                end
            endcase
            load_planes(set);
            tx_quiet = ($urandom_range(0, 2) == 0);
            rx_quiet = ($urandom_range(0, 2) == 0);
            // receiver holds off while a steady stream fills the pipe
            if (ph == 4) begin
                tx_quiet    = 1'b1;
                rx_hold_len = HOLD_CYCLES;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_box(random_box(), 1'b0, 1'b0);
            i_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && visible_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // output side stall, one draw per result
    initial begin : rx_side
        int unsigned pause;
        i_stall <= 1'b0;
        forever begin
            if (rx_hold_len != 0) begin
                i_stall <= 1'b1;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
                i_stall <= 1'b0;
            end else begin
                pause = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
                if (pause != 0) begin
                    i_stall <= 1'b1;
                    repeat (pause) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    // expected visible bits in, results out and compared
    always @(posedge i_clk) begin : check
        t_box taken;
        logic want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                taken = {i_min_x, i_max_x, i_min_y, i_max_y, i_min_z, i_max_z};
                visible_q.push_back(pin_on ? pin_val : box_visible(taken));
            end
            if (o_valid && !i_stall) begin
                if (visible_q.size() == 0) begin
                    $error("visible: result with none expected, got %0b", o_visible);
                    mismatch_count++;
                end else begin
                    want = visible_q.pop_front();
                    if (o_visible !== want) begin
                        $error("visible: expected %0b, got %0b", want, o_visible);
                        mismatch_count++;
                    end
                end
            end
        end
    end

endmodule
